// File: design/btab_pkg.sv
// Shared types, constants and helpers for the block table adjacency bitmap unit.
package btab_pkg;

    localparam int CAPACITY   = 64;
    localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ID_W       = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MD_INS_BLOCK = 2'd0,
        MD_INS_EDGE  = 2'd1,
        MD_LOOKUP    = 2'd2,
        MD_NEIGHBORS = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUP       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_NONE  = 2'd0,
        SL_HIT   = 2'd1,
        SL_COUNT = 2'd2,
        SL_SRC   = 2'd3
    } t_slot_sel;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_SRCH_A  = 3'd1,
        S_SRCH_B  = 3'd2,
        S_EDGE_WR = 3'd3,
        S_ROW_RD  = 3'd4,
        S_ROW     = 3'd5,
        S_NB_SCAN = 3'd6,
        S_NB_EMIT = 3'd7
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   block_id;
        logic [ID_W-1:0]   dest_block_id;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ID_W-1:0]       neighbor_id;
        logic                  neighbor_valid;
        logic                  last;
    } t_out_beat;

    typedef struct packed {
        logic      load_in;
        logic      srch_start;
        logic      srch_run;
        logic      key_dest;
        logic      save_src;
        logic      save_dst;
        logic      id_write;
        logic      row_rd;
        logic      row_wr;
        logic      row_load;
        logic      nb_step;
        logic      emit;
        t_status   status;
        t_slot_sel slot_sel;
        logic      nbr;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  hit;
        logic  miss;
        logic  full;
        logic  out_free;
        logic  row_zero;
        logic  row_bit0;
        logic  nb_last;
    } t_sts;

    // One bit per slot, set for the slots below the fill count.
    function automatic logic [CAPACITY-1:0] below_mask(input logic [CNT_W-1:0] count);
        logic [CAPACITY-1:0] m;
        for (int k = 0; k < CAPACITY; k++) begin
            m[k] = (k < int'(count));
        end
        return m;
    endfunction

endpackage

// File: design/btab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/btab_dpath.sv
// Datapath: id table and adjacency row memories, search and row scan registers, result register.
module btab_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btab_pkg::t_in_beat i_in_beat,
    input  logic               i_out_ready,
    input  btab_pkg::t_cmd     i_cmd,
    output btab_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output btab_pkg::t_out_beat o_out_beat
);

    btab_pkg::t_in_beat            r_in;
    logic                          r_key_dest;
    logic [btab_pkg::CNT_W-1:0]    r_count;
    logic [btab_pkg::CNT_W-1:0]    r_scan_idx;
    logic                          r_cmp_vld;
    logic [btab_pkg::SLOT_W-1:0]   r_cmp_idx;
    logic [btab_pkg::SLOT_W-1:0]   r_src_slot;
    logic [btab_pkg::SLOT_W-1:0]   r_dst_slot;
    logic [btab_pkg::CAPACITY-1:0] r_row_vld;
    logic [btab_pkg::CAPACITY-1:0] r_row;
    logic [btab_pkg::SLOT_W-1:0]   r_nb_idx;
    logic                          r_nb_last;
    logic                          r_out_valid;
    btab_pkg::t_out_beat           r_out_beat;

    logic [btab_pkg::ID_W-1:0]     key;
    logic                          scan_issue;
    logic                          nb_issue;
    logic                          id_re;
    logic [btab_pkg::SLOT_W-1:0]   id_raddr;
    logic [btab_pkg::ID_W-1:0]     id_q;
    logic [btab_pkg::CAPACITY-1:0] adj_q;
    logic [btab_pkg::CAPACITY-1:0] row_eff;
    logic [btab_pkg::CAPACITY-1:0] row_masked;
    logic [btab_pkg::CAPACITY-1:0] row_wdata;
    logic [btab_pkg::SLOT_W-1:0]   emit_slot;

    // The search key switches to the destination id once the edge source has been found.
    assign key        = r_key_dest ? r_in.dest_block_id : r_in.block_id;
    assign scan_issue = i_cmd.srch_run && (r_scan_idx < r_count);
    assign nb_issue   = i_cmd.nb_step && r_row[0];
    assign id_re      = scan_issue || nb_issue;
    assign id_raddr   = i_cmd.nb_step ? r_nb_idx : r_scan_idx[btab_pkg::SLOT_W-1:0];

    // A row that was never written reads as all zeros.
    assign row_eff    = r_row_vld[r_src_slot] ? adj_q : '0;
    assign row_masked = row_eff & btab_pkg::below_mask(r_count);
    assign row_wdata  = row_eff |
                        ({{(btab_pkg::CAPACITY-1){1'b0}}, 1'b1} << r_dst_slot);

    btab_ram #(
        .WIDTH (btab_pkg::ID_W),
        .DEPTH (btab_pkg::CAPACITY)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.id_write),
        .i_waddr (r_count[btab_pkg::SLOT_W-1:0]),
        .i_wdata (r_in.block_id),
        .i_re    (id_re),
        .i_raddr (id_raddr),
        .o_rdata (id_q)
    );

    btab_ram #(
        .WIDTH (btab_pkg::CAPACITY),
        .DEPTH (btab_pkg::CAPACITY)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.row_wr),
        .i_waddr (r_src_slot),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.row_rd),
        .i_raddr (r_src_slot),
        .o_rdata (adj_q)
    );

    always_comb begin
        o_sts.mode     = btab_pkg::t_mode'(r_in.mode);
        o_sts.hit      = r_cmp_vld && (id_q == key);
        o_sts.miss     = !r_cmp_vld && (r_scan_idx >= r_count);
        o_sts.full     = (r_count >= btab_pkg::CNT_W'(btab_pkg::CAPACITY));
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.row_zero = (row_masked == '0);
        o_sts.row_bit0 = r_row[0];
        o_sts.nb_last  = r_nb_last;
    end

    always_comb begin
        case (i_cmd.slot_sel)
            btab_pkg::SL_HIT:   emit_slot = r_cmp_idx;
            btab_pkg::SL_COUNT: emit_slot = r_count[btab_pkg::SLOT_W-1:0];
            btab_pkg::SL_SRC:   emit_slot = r_src_slot;
            default:            emit_slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.id_write) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.srch_start) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.srch_run) begin
                r_cmp_vld <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            if (i_cmd.row_wr) begin
                r_row_vld[r_src_slot] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in       <= i_in_beat;
            r_key_dest <= 1'b0;
        end else if (i_cmd.key_dest) begin
            r_key_dest <= 1'b1;
        end
        if (i_cmd.srch_run) begin
            r_cmp_idx <= r_scan_idx[btab_pkg::SLOT_W-1:0];
        end
        if (i_cmd.save_src) begin
            r_src_slot <= r_cmp_idx;
        end
        if (i_cmd.save_dst) begin
            r_dst_slot <= r_cmp_idx;
        end
        if (i_cmd.row_load) begin
            r_row    <= row_masked;
            r_nb_idx <= '0;
        end else if (i_cmd.nb_step) begin
            r_row    <= r_row >> 1;
            r_nb_idx <= r_nb_idx + 1'b1;
            if (r_row[0]) begin
                r_nb_last <= ((r_row >> 1) == '0);
            end
        end
        if (i_cmd.emit) begin
            r_out_beat.status         <= i_cmd.status;
            r_out_beat.slot_index     <= btab_pkg::SLOT_OUT_W'(emit_slot);
            r_out_beat.neighbor_id    <= i_cmd.nbr ? id_q : '0;
            r_out_beat.neighbor_valid <= i_cmd.nbr;
            r_out_beat.last           <= i_cmd.nbr ? r_nb_last : 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// File: design/btab_ctrl.sv
// Controller state machine that sequences searches, edge updates and neighbor listing.
module btab_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_accept,
    input  btab_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output btab_pkg::t_cmd o_cmd
);

    btab_pkg::t_state r_state;
    btab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btab_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            btab_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_accept) begin
                    o_cmd.load_in    = 1'b1;
                    o_cmd.srch_start = 1'b1;
                    n_state          = btab_pkg::S_SRCH_A;
                end
            end
            btab_pkg::S_SRCH_A: begin
                if (i_sts.mode == btab_pkg::MD_INS_BLOCK && i_sts.full) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.status   = btab_pkg::ST_FULL;
                        o_cmd.slot_sel = btab_pkg::SL_NONE;
                        n_state        = btab_pkg::S_IDLE;
                    end
                end else if (i_sts.hit) begin
                    case (i_sts.mode)
                        btab_pkg::MD_INS_BLOCK: begin
                            if (i_sts.out_free) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.status   = btab_pkg::ST_DUP;
                                o_cmd.slot_sel = btab_pkg::SL_HIT;
                                n_state        = btab_pkg::S_IDLE;
                            end
                        end
                        btab_pkg::MD_INS_EDGE: begin
                            o_cmd.save_src   = 1'b1;
                            o_cmd.srch_start = 1'b1;
                            o_cmd.key_dest   = 1'b1;
                            n_state          = btab_pkg::S_SRCH_B;
                        end
                        btab_pkg::MD_LOOKUP: begin
                            if (i_sts.out_free) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.status   = btab_pkg::ST_OK;
                                o_cmd.slot_sel = btab_pkg::SL_HIT;
                                n_state        = btab_pkg::S_IDLE;
                            end
                        end
                        default: begin
                            o_cmd.save_src = 1'b1;
                            n_state        = btab_pkg::S_ROW_RD;
                        end
                    endcase
                end else if (i_sts.miss) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = btab_pkg::S_IDLE;
                        if (i_sts.mode == btab_pkg::MD_INS_BLOCK) begin
                            o_cmd.status   = btab_pkg::ST_OK;
                            o_cmd.slot_sel = btab_pkg::SL_COUNT;
                            o_cmd.id_write = 1'b1;
                        end else begin
                            o_cmd.status   = btab_pkg::ST_NOT_FOUND;
                            o_cmd.slot_sel = btab_pkg::SL_NONE;
                        end
                    end
                end else begin
                    o_cmd.srch_run = 1'b1;
                end
            end
            btab_pkg::S_SRCH_B: begin
                if (i_sts.hit) begin
                    o_cmd.save_dst = 1'b1;
                    o_cmd.row_rd   = 1'b1;
                    n_state        = btab_pkg::S_EDGE_WR;
                end else if (i_sts.miss) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.status   = btab_pkg::ST_NOT_FOUND;
                        o_cmd.slot_sel = btab_pkg::SL_NONE;
                        n_state        = btab_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.srch_run = 1'b1;
                end
            end
            btab_pkg::S_EDGE_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.row_wr   = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = btab_pkg::ST_OK;
                    o_cmd.slot_sel = btab_pkg::SL_SRC;
                    n_state        = btab_pkg::S_IDLE;
                end
            end
            btab_pkg::S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = btab_pkg::S_ROW;
            end
            btab_pkg::S_ROW: begin
                if (i_sts.row_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.status   = btab_pkg::ST_OK;
                        o_cmd.slot_sel = btab_pkg::SL_SRC;
                        n_state        = btab_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.row_load = 1'b1;
                    n_state        = btab_pkg::S_NB_SCAN;
                end
            end
            btab_pkg::S_NB_SCAN: begin
                o_cmd.nb_step = 1'b1;
                if (i_sts.row_bit0) begin
                    n_state = btab_pkg::S_NB_EMIT;
                end
            end
            btab_pkg::S_NB_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.status   = btab_pkg::ST_OK;
                    o_cmd.slot_sel = btab_pkg::SL_SRC;
                    o_cmd.nbr      = 1'b1;
                    n_state        = i_sts.nb_last ? btab_pkg::S_IDLE : btab_pkg::S_NB_SCAN;
                end
            end
            default: begin
                n_state = btab_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: design/block_table_adjacency_bitmap_unit.sv
// Top level of the block id table with adjacency bit matrix: controller plus datapath.
// The id search reads one slot per cycle; a miss is known once all occupied slots are read,
// and a full insert is refused without a search. An edge searches for its source, then its
// destination, then reads and writes the source row; a listing reads the row, then steps
// through its bits up to the last set one, emitting a beat per neighbor. One item runs at a
// time; the next beat waits until the last result registers. Sync active-low reset only.
module block_table_adjacency_bitmap_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  btab_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output btab_pkg::t_out_beat o_out_beat
);

    // Command and status buses are the only link between the controller and the datapath.
    btab_pkg::t_cmd cmd;
    btab_pkg::t_sts sts;
    logic           in_accept;

    // An input beat is taken only while the controller sits idle. The result register in the
    // datapath lets a finished result wait for the consumer while the next beat is accepted.
    // Reset clears the fill count and the row valid bits; there is no clearing pass.
    assign in_accept = i_in_valid && o_in_ready;

    btab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the id table memory (searched linearly over the occupied slots),
    // the adjacency row memory with a valid bit per row standing in for the cleared reset,
    // and the output register that drives the result channel.
    btab_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// File: design/btab_chk.sv
// Port-level checker for the block table adjacency bitmap unit, bound to the top level.
module btab_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input btab_pkg::t_out_beat o_out_beat
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("result beat changed while stalled");

    // The block is not ready again in the cycle after it takes an input beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

    // A beat without a neighbor is always the final beat of its item and carries a zero id.
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.neighbor_valid) |->
        (o_out_beat.last && o_out_beat.neighbor_id == '0))
        else $error("non-neighbor beat not marked last");

    // Failures for a full table or a missing id report slot zero and no neighbor.
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.status == btab_pkg::ST_FULL ||
                         o_out_beat.status == btab_pkg::ST_NOT_FOUND)) |->
        (o_out_beat.slot_index == '0 && !o_out_beat.neighbor_valid))
        else $error("failure beat with nonzero slot or neighbor");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind block_table_adjacency_bitmap_unit btab_chk u_btab_chk (.*);

// File: tb/block_table_adjacency_bitmap_unit_tb.sv
// Self-checking testbench for the block id table with adjacency bit matrix.
`timescale 1ns / 100ps

module block_table_adjacency_bitmap_unit_tb;

    localparam int DIR_N        = 24;      // directed rows
    localparam int RAND_N       = 186;     // random input beats
    localparam int FILL_FORCE   = 110;     // random beat index from which the table is forced full
    localparam int DRAIN_CYCLES = 200;     // quiet time after the last result (walk + misses)
    localparam int CYCLE_LIMIT  = 400000;  // watchdog limit on the whole run

    // One directed stimulus row. A typed row carries its expected single result
    // (status and slot); every other row is checked against the predictor.
    typedef struct {
        btab_pkg::t_mode                     mode;
        logic [btab_pkg::ID_W-1:0]           id;
        logic [btab_pkg::ID_W-1:0]           dest;
        bit                                  typed;
        btab_pkg::t_status                   want_status;
        logic [btab_pkg::SLOT_OUT_W-1:0]     want_slot;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    btab_pkg::t_in_beat  i_in_beat   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b1;
    btab_pkg::t_out_beat o_out_beat;

    block_table_adjacency_bitmap_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the id table, its fill count and the matrix.
    logic [btab_pkg::ID_W-1:0]     stored_ids [btab_pkg::CAPACITY];
    int                            stored_count = 0;
    logic [btab_pkg::CAPACITY-1:0] adj_rows [btab_pkg::CAPACITY];

    btab_pkg::t_out_beat item_beats[$];     // results of the beat just predicted
    btab_pkg::t_out_beat awaited_beats[$];  // results still to come out of the block, oldest first

    t_dir_row dir_rows [DIR_N];

    int error_count   = 0;
    int cycle_count   = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int neighbor_outs = 0;
    int full_refusals = 0;
    int stall_left    = 0;

    // Lowest occupied slot holding the id, or -1 when the id is not stored.
    function automatic int slot_of(input logic [btab_pkg::ID_W-1:0] id);
        for (int k = 0; k < stored_count; k++) begin
            if (stored_ids[k] == id) begin
                return k;
            end
        end
        return -1;
    endfunction

    // Works out the results of one accepted beat and advances the predictor state.
    task automatic predict_beats(input btab_pkg::t_in_beat b);
        int                  s;
        int                  d;
        btab_pkg::t_out_beat r;
        btab_pkg::t_out_beat nb;
        item_beats.delete();
        r        = '0;
        r.status = btab_pkg::ST_OK;
        r.last   = 1'b1;
        s        = slot_of(b.block_id);
        case (btab_pkg::t_mode'(b.mode))
            btab_pkg::MD_INS_BLOCK: begin
                // Fullness wins over the duplicate search.
                if (stored_count >= btab_pkg::CAPACITY) begin
                    r.status = btab_pkg::ST_FULL;
                    full_refusals++;
                end else if (s >= 0) begin
                    r.status     = btab_pkg::ST_DUP;
                    r.slot_index = btab_pkg::SLOT_OUT_W'(s);
                end else begin
                    stored_ids[stored_count] = b.block_id;
                    r.slot_index             = btab_pkg::SLOT_OUT_W'(stored_count);
                    stored_count++;
                end
            end
            btab_pkg::MD_INS_EDGE: begin
                d = slot_of(b.dest_block_id);
                if (s >= 0 && d >= 0) begin
                    adj_rows[s][d] = 1'b1;
                    r.slot_index   = btab_pkg::SLOT_OUT_W'(s);
                end else begin
                    r.status = btab_pkg::ST_NOT_FOUND;
                end
            end
            btab_pkg::MD_LOOKUP: begin
                if (s >= 0) begin
                    r.slot_index = btab_pkg::SLOT_OUT_W'(s);
                end else begin
                    r.status = btab_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                if (s < 0) begin
                    r.status = btab_pkg::ST_NOT_FOUND;
                end else begin
                    r.slot_index = btab_pkg::SLOT_OUT_W'(s);
                    // Neighbors come out in slot order; only the final one is marked last.
                    for (int j = 0; j < stored_count; j++) begin
                        if (adj_rows[s][j]) begin
                            nb                = r;
                            nb.neighbor_id    = stored_ids[j];
                            nb.neighbor_valid = 1'b1;
                            nb.last           = 1'b0;
                            item_beats        = {item_beats, nb};
                            neighbor_outs++;
                        end
                    end
                    if (item_beats.size() > 0) begin
                        item_beats[item_beats.size()-1].last = 1'b1;
                    end
                end
            end
        endcase
        if (item_beats.size() == 0) begin
            item_beats = {item_beats, r};
        end
    endtask

    // Picks an id: a stored one with the given odds, otherwise a fresh value
    // that is occasionally one of the two extremes.
    function automatic logic [btab_pkg::ID_W-1:0] pick_id(input int known_pct);
        int r;
        r = $urandom_range(99);
        if (stored_count > 0 && r < known_pct) begin
            return stored_ids[$urandom_range(stored_count - 1)];
        end
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_dir_row mk_row(input btab_pkg::t_mode m,
                                        input logic [btab_pkg::ID_W-1:0] id,
                                        input logic [btab_pkg::ID_W-1:0] dest, input bit typed,
                                        input btab_pkg::t_status st,
                                        input logic [btab_pkg::SLOT_OUT_W-1:0] slot);
        t_dir_row row;
        row.mode        = m;
        row.id          = id;
        row.dest        = dest;
        row.typed       = typed;
        row.want_status = st;
        row.want_slot   = slot;
        return row;
    endfunction

    task automatic check_field(input string name, input logic [btab_pkg::ID_W-1:0] want,
                               input logic [btab_pkg::ID_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Directed rows: empty-table misses, the id extremes, a duplicate, an id without
    // neighbors, repeated and self edges, edges with a missing end, and listings.
    initial begin
        dir_rows[0]  = mk_row(btab_pkg::MD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[1]  = mk_row(btab_pkg::MD_NEIGHBORS, 32'hFFFF_FFFF, 32'h0000_0000,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[2]  = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'hFFFF_FFFF,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[3]  = mk_row(btab_pkg::MD_INS_BLOCK, 32'h0000_0000, 32'hFFFF_FFFF,
                              1, btab_pkg::ST_OK, 6'd0);
        dir_rows[4]  = mk_row(btab_pkg::MD_INS_BLOCK, 32'hFFFF_FFFF, 32'h0000_0000,
                              1, btab_pkg::ST_OK, 6'd1);
        dir_rows[5]  = mk_row(btab_pkg::MD_INS_BLOCK, 32'h0000_0000, 32'h1234_5678,
                              1, btab_pkg::ST_DUP, 6'd0);
        dir_rows[6]  = mk_row(btab_pkg::MD_NEIGHBORS, 32'h0000_0000, 32'hFFFF_FFFF,
                              1, btab_pkg::ST_OK, 6'd0);
        dir_rows[7]  = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[8]  = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[9]  = mk_row(btab_pkg::MD_INS_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[10] = mk_row(btab_pkg::MD_INS_EDGE, 32'hFFFF_FFFF, 32'h0000_0000,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[11] = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'h0000_0000,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[12] = mk_row(btab_pkg::MD_INS_BLOCK, 32'hA5A5_A5A5, 32'h0000_0000,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[13] = mk_row(btab_pkg::MD_INS_BLOCK, 32'h5A5A_5A5A, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[14] = mk_row(btab_pkg::MD_INS_EDGE, 32'hA5A5_A5A5, 32'h1234_5678,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[15] = mk_row(btab_pkg::MD_INS_EDGE, 32'h1234_5678, 32'h0000_0000,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[16] = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'h5A5A_5A5A,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[17] = mk_row(btab_pkg::MD_INS_EDGE, 32'h0000_0000, 32'hA5A5_A5A5,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[18] = mk_row(btab_pkg::MD_NEIGHBORS, 32'h0000_0000, 32'h0000_0000,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[19] = mk_row(btab_pkg::MD_NEIGHBORS, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[20] = mk_row(btab_pkg::MD_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[21] = mk_row(btab_pkg::MD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              0, btab_pkg::ST_OK, 6'd0);
        dir_rows[22] = mk_row(btab_pkg::MD_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000,
                              1, btab_pkg::ST_NOT_FOUND, 6'd0);
        dir_rows[23] = mk_row(btab_pkg::MD_NEIGHBORS, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                              0, btab_pkg::ST_OK, 6'd0);
    end

    // Reset is held from the start and released once.
    initial begin
        for (int k = 0; k < btab_pkg::CAPACITY; k++) begin
            adj_rows[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stimulus: the directed table first, then random beats. Every beat is predicted at
    // the edge where it is accepted, so the predictor sees exactly what the block sees.
    initial begin : stimulus
        btab_pkg::t_in_beat  beat;
        btab_pkg::t_out_beat want;
        btab_pkg::t_mode     m;
        int                  idx;
        int                  ridx;
        int                  gap;
        int                  pick;
        bit                  typed;

        repeat (4) @(posedge i_clk);
        for (idx = 0; idx < DIR_N + RAND_N; idx++) begin
            typed = 1'b0;
            if (idx < DIR_N) begin
                beat.mode          = dir_rows[idx].mode;
                beat.block_id      = dir_rows[idx].id;
                beat.dest_block_id = dir_rows[idx].dest;
                typed              = dir_rows[idx].typed;
                want               = '0;
                want.status        = dir_rows[idx].want_status;
                want.slot_index    = dir_rows[idx].want_slot;
                want.last          = 1'b1;
            end else begin
                ridx = idx - DIR_N;
                pick = $urandom_range(99);
                // Late in the run the table is pushed to capacity so that the full
                // case and the widest rows are reached.
                if (ridx >= FILL_FORCE && stored_count < btab_pkg::CAPACITY) begin
                    m = btab_pkg::MD_INS_BLOCK;
                end else if (pick < 40) begin
                    m = btab_pkg::MD_INS_BLOCK;
                end else if (pick < 70) begin
                    m = btab_pkg::MD_INS_EDGE;
                end else if (pick < 85) begin
                    m = btab_pkg::MD_LOOKUP;
                end else begin
                    m = btab_pkg::MD_NEIGHBORS;
                end
                beat.mode = m;
                // Mostly well-formed traffic: new ids for inserts, stored ids elsewhere;
                // the remainder is duplicates and misses. Dest is noise outside edges.
                if (m == btab_pkg::MD_INS_BLOCK) begin
                    beat.block_id = pick_id((ridx >= FILL_FORCE) ? 0 : 15);
                end else begin
                    beat.block_id = pick_id(85);
                end
                beat.dest_block_id = (m == btab_pkg::MD_INS_EDGE) ? pick_id(85) : $urandom;
            end

            // Input side may idle before each beat, except in gap-free stretches.
            gap = ((idx / 40) % 3 == 2) ? 0 : $urandom_range(3);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_beat  <= beat;
            do @(posedge i_clk); while (!o_in_ready);
            beats_in++;

            predict_beats(beat);
            if (typed) begin
                awaited_beats = {awaited_beats, want};
            end else begin
                awaited_beats = {awaited_beats, item_beats};
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for the last expected result, then look for strays.
        while (awaited_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input beats (%0d directed), %0d result beats, %0d neighbors.",
                 beats_in, DIR_N, beats_out, neighbor_outs);
        $display("Table filled to %0d of %0d slots; %0d inserts were refused as full.",
                 stored_count, btab_pkg::CAPACITY, full_refusals);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: every accepted beat is compared field by field with the oldest
    // expectation, then ready may drop for a random stall, except in stall-free stretches.
    always @(posedge i_clk) begin : result_check
        btab_pkg::t_out_beat want;
        int                  stall;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (awaited_beats.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, expected none, actual %0h",
                         $time, o_out_beat);
            end else begin
                want = awaited_beats.pop_front();
                check_field("status", btab_pkg::ID_W'(want.status),
                            btab_pkg::ID_W'(o_out_beat.status));
                check_field("slot_index", btab_pkg::ID_W'(want.slot_index),
                            btab_pkg::ID_W'(o_out_beat.slot_index));
                check_field("neighbor_id", want.neighbor_id, o_out_beat.neighbor_id);
                check_field("neighbor_valid", btab_pkg::ID_W'(want.neighbor_valid),
                            btab_pkg::ID_W'(o_out_beat.neighbor_valid));
                check_field("last", btab_pkg::ID_W'(want.last),
                            btab_pkg::ID_W'(o_out_beat.last));
            end
            stall       = ((cycle_count / 300) % 3 == 1) ? 0 : $urandom_range(3);
            stall_left  <= stall;
            i_out_ready <= (stall == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
